// File: design/sal_pkg.sv
`timescale 1ns / 1ps

package sal_pkg;

  localparam int FieldW = 7;
  localparam int RectW  = 8;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PASS_A,
    ST_PASS_B,
    ST_DECIDE,
    ST_WRITE,
    ST_DONE
  } sal_state_e;

  typedef enum logic [1:0] {
    STAT_PLACED     = 2'd0,
    STAT_NEW_PAGE   = 2'd1,
    STAT_PAGE_LIMIT = 2'd2,
    STAT_NEVER_FITS = 2'd3
  } sal_status_e;

  // Where the sequencer goes once a clearing sweep of the skyline ends.
  typedef enum logic [1:0] {
    CLR_TO_IDLE,
    CLR_TO_BEGIN,
    CLR_TO_SCAN
  } sal_clr_e;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_BEGIN = 1'b1
  } sal_cmd_e;

  typedef struct packed {
    logic             start;
    sal_cmd_e         command;
    logic [RectW-1:0] rect_width;
    logic [RectW-1:0] rect_height;
  } sal_req_t;

  typedef struct packed {
    logic              valid;
    logic [FieldW-1:0] page;
    logic [FieldW-1:0] x_pos;
    logic [FieldW-1:0] y_pos;
    sal_status_e       status;
  } sal_rsp_t;

endpackage

// File: design/sal_core.sv
`timescale 1ns / 1ps

module sal_core import sal_pkg::*; #(
  parameter int PAGE_W    = 128,
  parameter int PAGE_H    = 128,
  parameter int MAX_PAGES = 128
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  sal_req_t req_i,
  output logic     idle_o,
  output sal_rsp_t rsp_o,
  input  logic     rsp_ack_i
);

  localparam int CW  = $clog2(PAGE_W);
  localparam int HW  = $clog2(PAGE_H + 1);
  localparam int PGW = $clog2(MAX_PAGES);
  localparam int XW  = (CW + 1 > 9) ? CW + 1 : 9;
  localparam int SW  = ((HW > RectW) ? HW : RectW) + 1;

  localparam logic [XW-1:0]  LastScan = XW'(PAGE_W - 2);
  localparam logic [XW-1:0]  ColEnd   = XW'(PAGE_W - 1);
  localparam logic [XW-1:0]  PageWX   = XW'(PAGE_W);
  localparam logic [HW-1:0]  PageHH   = HW'(PAGE_H);
  localparam logic [SW-1:0]  PageHS   = SW'(PAGE_H);
  localparam logic [PGW:0]   MaxPg    = (PGW + 1)'(MAX_PAGES);

  sal_state_e state_q, state_d;
  sal_clr_e   clr_next_q;

  logic [XW-1:0]    cnt_q;
  logic             rd_vld_q;
  logic [CW-1:0]    rd_idx_q;
  logic [RectW-1:0] k_q;
  logic [HW-1:0]    run_q;
  logic             found_q;
  logic             retry_q;
  logic [HW-1:0]    best_q;
  logic [CW-1:0]    bx_q;
  logic [RectW-1:0] w_q;
  logic [RectW-1:0] h_q;
  logic [PGW-1:0]   page_q;
  logic [FieldW-1:0] x_q;
  logic [FieldW-1:0] y_q;
  sal_status_e      status_q;

  // Skyline heights and per-block prefix maxima.
  logic [HW-1:0] hgt_mem [PAGE_W];
  logic [HW-1:0] pmx_mem [PAGE_W];
  logic [HW-1:0] hgt_rd_q;
  logic [HW-1:0] pmx_rd_q;

  logic          hgt_we;
  logic [CW-1:0] hgt_waddr;
  logic [HW-1:0] hgt_wdata;
  logic [CW-1:0] hgt_raddr;
  logic          pmx_we;
  logic [CW-1:0] pmx_raddr;
  logic          issue;
  logic [CW-1:0] issue_idx;

  logic [XW-1:0]    w_ext;
  logic [RectW-1:0] wm1;
  logic [XW-1:0]    scan_b_idx;
  logic [XW-1:0]    win_end;
  logic [XW-1:0]    wr_addr;
  logic             scan_done;
  logic             clr_done;
  logic             wr_done;
  logic             blk_restart;
  logic [HW-1:0]    mx_y;
  logic [HW-1:0]    seg;
  logic [HW-1:0]    win;
  logic             cand;
  logic             take;
  logic [RectW-1:0] k_inc;
  logic [RectW-1:0] k_dec;
  logic [SW-1:0]    top_sum;
  logic             fits;
  logic             never_fits;
  logic             at_limit;
  logic             skip_scan;
  logic [CW+FieldW-1:0]  bx_ext;
  logic [HW+FieldW-1:0]  best_ext;
  logic [PGW+FieldW-1:0] page_ext;

  assign w_ext      = XW'(w_q);
  assign wm1        = w_q - RectW'(1);
  assign scan_b_idx = LastScan - cnt_q;
  assign win_end    = scan_b_idx + w_ext - XW'(1);
  assign wr_addr    = XW'(bx_q) + cnt_q;
  assign issue      = (state_q == ST_PASS_A || state_q == ST_PASS_B) && (cnt_q <= LastScan);
  assign scan_done  = (cnt_q > LastScan) && !rd_vld_q;
  assign clr_done   = (cnt_q == ColEnd);
  assign wr_done    = (cnt_q == w_ext - XW'(1));
  assign skip_scan  = (req_i.rect_width == '0) || (XW'(req_i.rect_width) >= PageWX);

  // The shared max unit serves both the prefix pass and the suffix pass.
  assign mx_y = (run_q > hgt_rd_q) ? run_q : hgt_rd_q;

  // A block of w columns restarts at its first column going forward and at
  // its last column going backward.
  assign blk_restart = (state_q == ST_PASS_A) ? (k_q == '0) : (k_q == wm1);
  assign seg         = blk_restart ? hgt_rd_q : mx_y;
  assign k_inc       = (k_q == wm1) ? '0 : k_q + RectW'(1);
  assign k_dec       = (k_q == '0) ? wm1 : k_q - RectW'(1);

  // Window max is the suffix of the left block joined with the prefix of the right.
  assign win  = (seg > pmx_rd_q) ? seg : pmx_rd_q;
  assign cand = (XW'(rd_idx_q) + w_ext) <= ColEnd;
  assign take = (state_q == ST_PASS_B) && rd_vld_q && cand && (win < PageHH) &&
                (!found_q || (win <= best_q));

  assign top_sum    = SW'(best_q) + SW'(h_q);
  assign fits       = found_q && (top_sum <= PageHS);
  assign never_fits = (w_ext >= PageWX) || (SW'(h_q) > PageHS);
  assign at_limit   = ((PGW + 1)'(page_q) + (PGW + 1)'(1)) >= MaxPg;

  assign bx_ext   = {{FieldW{1'b0}}, bx_q};
  assign best_ext = {{FieldW{1'b0}}, best_q};
  assign page_ext = {{FieldW{1'b0}}, page_q};

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_done) begin
          case (clr_next_q)
            CLR_TO_BEGIN: state_d = ST_DONE;
            CLR_TO_SCAN:  state_d = ST_PASS_A;
            default:      state_d = ST_IDLE;
          endcase
        end
      end
      ST_IDLE: begin
        if (req_i.start) begin
          if (req_i.command == CMD_BEGIN) begin
            state_d = ST_CLEAR;
          end else if (skip_scan) begin
            state_d = ST_DECIDE;
          end else begin
            state_d = ST_PASS_A;
          end
        end
      end
      ST_PASS_A: begin
        if (scan_done) state_d = ST_PASS_B;
      end
      ST_PASS_B: begin
        if (scan_done) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (fits) begin
          state_d = (w_q == '0) ? ST_DONE : ST_WRITE;
        end else if (never_fits || at_limit) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_CLEAR;
        end
      end
      ST_WRITE: begin
        if (wr_done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (rsp_ack_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    hgt_we    = 1'b0;
    hgt_waddr = cnt_q[CW-1:0];
    hgt_wdata = '0;
    hgt_raddr = cnt_q[CW-1:0];
    pmx_raddr = win_end[CW-1:0];
    issue_idx = cnt_q[CW-1:0];
    pmx_we    = rd_vld_q && (state_q == ST_PASS_A);
    case (state_q)
      ST_CLEAR: begin
        hgt_we = 1'b1;
      end
      ST_PASS_B: begin
        hgt_raddr = scan_b_idx[CW-1:0];
        issue_idx = scan_b_idx[CW-1:0];
      end
      ST_WRITE: begin
        hgt_we    = 1'b1;
        hgt_waddr = wr_addr[CW-1:0];
        hgt_wdata = top_sum[HW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (hgt_we) hgt_mem[hgt_waddr] <= hgt_wdata;
    hgt_rd_q <= hgt_mem[hgt_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (pmx_we) pmx_mem[rd_idx_q] <= seg;
    pmx_rd_q <= pmx_mem[pmx_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_next_q <= CLR_TO_IDLE;
      cnt_q      <= '0;
      rd_vld_q   <= 1'b0;
      found_q    <= 1'b0;
      retry_q    <= 1'b0;
      page_q     <= PGW'(1);
    end else begin
      state_q  <= state_d;
      rd_vld_q <= issue;
      case (state_q)
        ST_CLEAR: begin
          cnt_q <= clr_done ? '0 : cnt_q + XW'(1);
        end
        ST_IDLE: begin
          cnt_q <= '0;
          if (req_i.start) begin
            retry_q <= 1'b0;
            if (req_i.command == CMD_BEGIN) begin
              page_q     <= PGW'(1);
              clr_next_q <= CLR_TO_BEGIN;
              found_q    <= 1'b0;
            end else begin
              found_q <= (req_i.rect_width == '0);
            end
          end
        end
        ST_PASS_A: begin
          cnt_q <= scan_done ? '0 : (issue ? cnt_q + XW'(1) : cnt_q);
        end
        ST_PASS_B: begin
          cnt_q <= scan_done ? '0 : (issue ? cnt_q + XW'(1) : cnt_q);
          if (take) found_q <= 1'b1;
        end
        ST_DECIDE: begin
          cnt_q <= '0;
          if (!fits && !never_fits && !at_limit) begin
            page_q     <= page_q + PGW'(1);
            retry_q    <= 1'b1;
            clr_next_q <= CLR_TO_SCAN;
            found_q    <= 1'b0;
          end
        end
        ST_WRITE: begin
          cnt_q <= cnt_q + XW'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= issue_idx;
    case (state_q)
      ST_IDLE: begin
        k_q   <= '0;
        run_q <= '0;
        if (req_i.start) begin
          w_q      <= req_i.rect_width;
          h_q      <= req_i.rect_height;
          best_q   <= '0;
          bx_q     <= '0;
          x_q      <= '0;
          y_q      <= '0;
          status_q <= STAT_PLACED;
        end
      end
      ST_CLEAR: begin
        k_q   <= '0;
        run_q <= '0;
      end
      ST_PASS_A: begin
        if (rd_vld_q) begin
          k_q   <= k_inc;
          run_q <= seg;
        end else if (scan_done) begin
          // Step back from the column past the scan to its last column.
          k_q   <= k_dec;
          run_q <= '0;
        end
      end
      ST_PASS_B: begin
        if (rd_vld_q) begin
          k_q   <= k_dec;
          run_q <= seg;
        end
        if (take) begin
          best_q <= win;
          bx_q   <= rd_idx_q;
        end
      end
      ST_DECIDE: begin
        if (fits) begin
          x_q      <= bx_ext[FieldW-1:0];
          y_q      <= best_ext[FieldW-1:0];
          status_q <= retry_q ? STAT_NEW_PAGE : STAT_PLACED;
        end else begin
          x_q      <= '0;
          y_q      <= '0;
          status_q <= never_fits ? STAT_NEVER_FITS : STAT_PAGE_LIMIT;
        end
      end
      default: ;
    endcase
  end

  assign idle_o       = (state_q == ST_IDLE);
  assign rsp_o.valid  = (state_q == ST_DONE);
  assign rsp_o.page   = page_ext[FieldW-1:0];
  assign rsp_o.x_pos  = x_q;
  assign rsp_o.y_pos  = y_q;
  assign rsp_o.status = status_q;

  a_write_needs_fit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WRITE |-> found_q)
    else $error("skyline write without a found window");

  a_best_in_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> best_q < PageHH)
    else $error("best height outside the page");

  a_read_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == ST_PASS_A || state_q == ST_PASS_B))
    else $error("scan read data left over after the pass");

  a_retry_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR && clr_next_q == CLR_TO_SCAN) |-> retry_q)
    else $error("new page clear without retry mark");

  a_window_in_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DECIDE && found_q && w_q != '0) |-> (XW'(bx_q) + w_ext) <= ColEnd)
    else $error("chosen window crosses the last column");

endmodule

// File: design/skyline_atlas_allocator.sv
`timescale 1ns / 1ps

// Skyline allocator for atlas pages of PAGE_W by PAGE_H.
// Input stream: tuser carries the command (allocate or begin), tdata the
// rectangle width and height. Every input transaction gives exactly one
// output transaction: tdata carries page, x and y, tuser the status.
// For an allocate that scans, a forward pass builds per-block prefix maxima
// of the column heights. A backward pass forms the window maxima with one
// shared max unit. A decide state follows, and a placed window's w columns
// are then raised one per cycle. The passes are bounded by the single read
// port of the height memory. When the rectangle spills onto a new page, a
// clearing sweep and a second scan follow. A zero width, or a width of
// PAGE_W or more, skips the scan. A begin runs a clearing sweep. After reset
// the height memory is swept to zero while the input is not ready. One item
// is in work at a time, and the input is ready again in the cycle its result
// appears at the output. While the receiver stalls, one result waits at the
// output and the next one in the core, which then holds the input off.
module skyline_atlas_allocator import sal_pkg::*; #(
  parameter int PAGE_W    = 128,
  parameter int PAGE_H    = 128,
  parameter int MAX_PAGES = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // rect_width[7:0], rect_height[15:8]
  input  logic [0:0]  s_axis_tuser_i,   // command[0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // page[6:0], x_pos[13:7], y_pos[20:14], zero[23:21]
  output logic [1:0]  m_axis_tuser_o    // status[1:0]
);

  sal_req_t req;
  sal_rsp_t rsp;
  logic     core_idle;
  logic     rsp_ack;

  logic              out_vld_q;
  logic [FieldW-1:0] out_page_q;
  logic [FieldW-1:0] out_x_q;
  logic [FieldW-1:0] out_y_q;
  sal_status_e       out_status_q;

  assign s_axis_tready_o = core_idle;

  assign req.start       = s_axis_tvalid_i && core_idle;
  assign req.command     = sal_cmd_e'(s_axis_tuser_i[0]);
  assign req.rect_width  = s_axis_tdata_i[7:0];
  assign req.rect_height = s_axis_tdata_i[15:8];

  assign rsp_ack = rsp.valid && (!out_vld_q || m_axis_tready_i);

  sal_core #(
    .PAGE_W   (PAGE_W),
    .PAGE_H   (PAGE_H),
    .MAX_PAGES(MAX_PAGES)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req),
    .idle_o   (core_idle),
    .rsp_o    (rsp),
    .rsp_ack_i(rsp_ack)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (rsp_ack) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_ack) begin
      out_page_q   <= rsp.page;
      out_x_q      <= rsp.x_pos;
      out_y_q      <= rsp.y_pos;
      out_status_q <= rsp.status;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {3'b000, out_y_q, out_x_q, out_page_q};
  assign m_axis_tuser_o  = out_status_q;

endmodule
